@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the lfu cache table rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lct assertion failed");

// next-cycle implication, disabled while reset is low
`define LCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lct assertion failed");

`endif

@@ rtl/core/lct_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and types for the lfu cache table
// no dependencies
package lct_pkg;

    // fixed field widths
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 16;
    localparam int STAMP_W = 48;
    localparam int CFG_W   = 5;

    // parameter defaults
    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 16;

    // capacity register reset value
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // saturation limit of the use count
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // action codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // commit command broadcast to the selected cell
    typedef struct packed {
        logic load;     // insert new key with count one
        logic touch;    // bump count and restamp
        logic wr_data;  // replace stored data on touch
    } t_lct_cmd;

endpackage

@@ rtl/core/lct_req_if.sv @@
`timescale 1ns / 1ps
// request channel of the lfu cache table: action, key, value
// depends on lct_pkg
interface lct_req_if
    import lct_pkg::*;
#(
    parameter int KEY_W = KEY_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;

    modport source (output valid, action, key, value, input ready);
    modport sink   (input valid, action, key, value, output ready);
endinterface

@@ rtl/core/lct_rsp_if.sv @@
`timescale 1ns / 1ps
// response channel of the lfu cache table: hit, read value, eviction
// depends on lct_pkg
interface lct_rsp_if
    import lct_pkg::*;
#(
    parameter int KEY_W = KEY_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

@@ rtl/core/lct_cfg_if.sv @@
`timescale 1ns / 1ps
// configuration write channel: capacity in use
// depends on lct_pkg
interface lct_cfg_if
    import lct_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] capacity_in_use;

    modport source (output valid, capacity_in_use, input ready);
    modport sink   (input valid, capacity_in_use, output ready);
endinterface

@@ rtl/core/lct_cell.sv @@
`timescale 1ns / 1ps
// one entry of the lfu cache table plus one hop of the search token
// depends on lct_pkg
module lct_cell
    import lct_pkg::*;
#(
    parameter int               IDX_W    = 4,
    parameter int               KEY_W    = KEY_BITS_DEF,
    parameter logic [IDX_W-1:0] CELL_IDX = '0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // operation word and commit command
    input  logic [KEY_W-1:0]   i_op_key,
    input  logic [DATA_W-1:0]  i_op_value,
    input  logic [STAMP_W-1:0] i_op_stamp,
    input  t_lct_cmd           i_cmd,
    input  logic [IDX_W-1:0]   i_sel_idx,
    // token from the previous cell
    input  logic               i_hit,
    input  logic [IDX_W-1:0]   i_hit_idx,
    input  logic [DATA_W-1:0]  i_hit_data,
    input  logic               i_any,
    input  logic [IDX_W-1:0]   i_best_idx,
    input  logic [CNT_W-1:0]   i_best_cnt,
    input  logic [STAMP_W-1:0] i_best_stamp,
    input  logic [KEY_W-1:0]   i_best_key,
    input  logic               i_free,
    input  logic [IDX_W-1:0]   i_free_idx,
    // token to the next cell
    output logic               o_hit,
    output logic [IDX_W-1:0]   o_hit_idx,
    output logic [DATA_W-1:0]  o_hit_data,
    output logic               o_any,
    output logic [IDX_W-1:0]   o_best_idx,
    output logic [CNT_W-1:0]   o_best_cnt,
    output logic [STAMP_W-1:0] o_best_stamp,
    output logic [KEY_W-1:0]   o_best_key,
    output logic               o_free,
    output logic [IDX_W-1:0]   o_free_idx
);

    // entry state
    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [DATA_W-1:0]  r_data;
    logic [CNT_W-1:0]   r_cnt;
    logic [STAMP_W-1:0] r_stamp;

    // token registers
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic [DATA_W-1:0]  r_hit_data, n_hit_data;
    logic               r_any, n_any;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic [CNT_W-1:0]   r_best_cnt, n_best_cnt;
    logic [STAMP_W-1:0] r_best_stamp, n_best_stamp;
    logic [KEY_W-1:0]   r_best_key, n_best_key;
    logic               r_free, n_free;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;

    logic sel;
    logic key_match;
    logic better;

    assign sel       = (i_sel_idx == CELL_IDX);
    assign key_match = r_valid && (r_key == i_op_key);
    // strict compares keep the lowest index on a full tie
    assign better    = r_valid && (!i_any || (r_cnt < i_best_cnt) ||
                       ((r_cnt == i_best_cnt) && (r_stamp < i_best_stamp)));

    // token update for this hop
    always_comb begin
        n_hit        = i_hit;
        n_hit_idx    = i_hit_idx;
        n_hit_data   = i_hit_data;
        n_any        = i_any;
        n_best_idx   = i_best_idx;
        n_best_cnt   = i_best_cnt;
        n_best_stamp = i_best_stamp;
        n_best_key   = i_best_key;
        n_free       = i_free;
        n_free_idx   = i_free_idx;
        if (!i_hit && key_match) begin
            n_hit      = 1'b1;
            n_hit_idx  = CELL_IDX;
            n_hit_data = r_data;
        end
        if (better) begin
            n_any        = 1'b1;
            n_best_idx   = CELL_IDX;
            n_best_cnt   = r_cnt;
            n_best_stamp = r_stamp;
            n_best_key   = r_key;
        end
        if (!i_free && !r_valid) begin
            n_free     = 1'b1;
            n_free_idx = CELL_IDX;
        end
    end

    // token hop register
    always_ff @(posedge i_clk) begin
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_data   <= n_hit_data;
        r_any        <= n_any;
        r_best_idx   <= n_best_idx;
        r_best_cnt   <= n_best_cnt;
        r_best_stamp <= n_best_stamp;
        r_best_key   <= n_best_key;
        r_free       <= n_free;
        r_free_idx   <= n_free_idx;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (sel && i_cmd.load) begin
            r_valid <= 1'b1;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (sel && i_cmd.load) begin
            r_key   <= i_op_key;
            r_data  <= i_op_value;
            r_cnt   <= CNT_W'(1);
            r_stamp <= i_op_stamp;
        end else if (sel && i_cmd.touch) begin
            if (r_cnt != CNT_MAX) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_stamp <= i_op_stamp;
            if (i_cmd.wr_data) begin
                r_data <= i_op_value;
            end
        end
    end

    assign o_hit        = r_hit;
    assign o_hit_idx    = r_hit_idx;
    assign o_hit_data   = r_hit_data;
    assign o_any        = r_any;
    assign o_best_idx   = r_best_idx;
    assign o_best_cnt   = r_best_cnt;
    assign o_best_stamp = r_best_stamp;
    assign o_best_key   = r_best_key;
    assign o_free       = r_free;
    assign o_free_idx   = r_free_idx;

endmodule

@@ rtl/core/lfu_cache_table.sv @@
`timescale 1ns / 1ps
// lfu cache table: a row of ENTRIES cells; a search token walks one cell per cycle
// an accepted request word is latched, the token walks the row, then the commit state
// updates the selected cell and the output register, stalling while it is still full
// requests are taken only in idle, also while the last response waits in that register
// reset (synchronous, active low) empties all entries, zeroes stamp and occupancy,
// sets capacity in use to 16
`include "assert_macros.svh"
module lfu_cache_table
    import lct_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lct_req_if.sink   i_req,
    lct_rsp_if.source o_rsp,
    lct_cfg_if.sink   i_cfg
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = ((OCC_W > CFG_W) ? OCC_W : CFG_W) + 1;
    localparam logic [IDX_W-1:0] LAST_HOP = IDX_W'(ENTRIES - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_hop, n_hop;
    logic [CFG_W-1:0]    r_cap;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [STAMP_W-1:0]  r_stamp;

    // latched request word
    logic                r_action;
    logic [KEY_BITS-1:0] r_key;
    logic [DATA_W-1:0]   r_value;

    // response register
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    logic [DATA_W-1:0]   r_out_rdata, n_out_rdata;
    logic                r_out_evicted, n_out_evicted;
    logic [KEY_BITS-1:0] r_out_ekey, n_out_ekey;

    // token wires along the cell row
    logic                tk_hit       [0:ENTRIES];
    logic [IDX_W-1:0]    tk_hit_idx   [0:ENTRIES];
    logic [DATA_W-1:0]   tk_hit_data  [0:ENTRIES];
    logic                tk_any       [0:ENTRIES];
    logic [IDX_W-1:0]    tk_best_idx  [0:ENTRIES];
    logic [CNT_W-1:0]    tk_best_cnt  [0:ENTRIES];
    logic [STAMP_W-1:0]  tk_best_stamp[0:ENTRIES];
    logic [KEY_BITS-1:0] tk_best_key  [0:ENTRIES];
    logic                tk_free      [0:ENTRIES];
    logic [IDX_W-1:0]    tk_free_idx  [0:ENTRIES];

    t_lct_cmd            cmd;
    logic [IDX_W-1:0]    sel_idx;
    logic                req_fire;
    logic                commit_go;
    logic [CFG_W-1:0]    cap_eff;
    logic                full;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign commit_go   = (r_state == S_COMMIT) && (!r_out_valid || o_rsp.ready);

    // capacity zero acts as one; capacity above ENTRIES acts as ENTRIES
    assign cap_eff = (r_cap == '0) ? CFG_W'(1) : r_cap;
    assign full    = (CMP_W'(r_occ) >= CMP_W'(cap_eff)) ||
                     (CMP_W'(r_occ) >= CMP_W'(ENTRIES));

    // empty token enters the first cell
    assign tk_hit[0]        = 1'b0;
    assign tk_hit_idx[0]    = '0;
    assign tk_hit_data[0]   = '0;
    assign tk_any[0]        = 1'b0;
    assign tk_best_idx[0]   = '0;
    assign tk_best_cnt[0]   = '0;
    assign tk_best_stamp[0] = '0;
    assign tk_best_key[0]   = '0;
    assign tk_free[0]       = 1'b0;
    assign tk_free_idx[0]   = '0;

    // cell row
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lct_cell #(
            .IDX_W    (IDX_W),
            .KEY_W    (KEY_BITS),
            .CELL_IDX (IDX_W'(g))
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op_key     (r_key),
            .i_op_value   (r_value),
            .i_op_stamp   (r_stamp),
            .i_cmd        (cmd),
            .i_sel_idx    (sel_idx),
            .i_hit        (tk_hit[g]),
            .i_hit_idx    (tk_hit_idx[g]),
            .i_hit_data   (tk_hit_data[g]),
            .i_any        (tk_any[g]),
            .i_best_idx   (tk_best_idx[g]),
            .i_best_cnt   (tk_best_cnt[g]),
            .i_best_stamp (tk_best_stamp[g]),
            .i_best_key   (tk_best_key[g]),
            .i_free       (tk_free[g]),
            .i_free_idx   (tk_free_idx[g]),
            .o_hit        (tk_hit[g+1]),
            .o_hit_idx    (tk_hit_idx[g+1]),
            .o_hit_data   (tk_hit_data[g+1]),
            .o_any        (tk_any[g+1]),
            .o_best_idx   (tk_best_idx[g+1]),
            .o_best_cnt   (tk_best_cnt[g+1]),
            .o_best_stamp (tk_best_stamp[g+1]),
            .o_best_key   (tk_best_key[g+1]),
            .o_free       (tk_free[g+1]),
            .o_free_idx   (tk_free_idx[g+1])
        );
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_hop   = r_hop;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_WALK;
                    n_hop   = '0;
                end
            end
            S_WALK: begin
                if (r_hop == LAST_HOP) begin
                    n_state = S_COMMIT;
                end else begin
                    n_hop = r_hop + 1'b1;
                end
            end
            S_COMMIT: begin
                if (commit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commit decision from the token at the end of the row
    always_comb begin
        cmd           = '0;
        sel_idx       = '0;
        n_occ         = r_occ;
        n_out_hit     = 1'b0;
        n_out_rdata   = '0;
        n_out_evicted = 1'b0;
        n_out_ekey    = '0;
        if (commit_go) begin
            if (tk_hit[ENTRIES]) begin
                cmd.touch   = 1'b1;
                cmd.wr_data = (r_action == ACT_PUT);
                sel_idx     = tk_hit_idx[ENTRIES];
                n_out_hit   = 1'b1;
                if (r_action == ACT_GET) begin
                    n_out_rdata = tk_hit_data[ENTRIES];
                end
            end else if (r_action == ACT_PUT) begin
                if (full && tk_any[ENTRIES]) begin
                    // evict and reuse the slot, occupancy unchanged
                    cmd.load      = 1'b1;
                    sel_idx       = tk_best_idx[ENTRIES];
                    n_out_evicted = 1'b1;
                    n_out_ekey    = tk_best_key[ENTRIES];
                end else if (tk_free[ENTRIES]) begin
                    cmd.load = 1'b1;
                    sel_idx  = tk_free_idx[ENTRIES];
                    n_occ    = r_occ + 1'b1;
                end
            end
        end
    end

    // response valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (commit_go) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hop       <= '0;
            r_occ       <= '0;
            r_stamp     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hop       <= n_hop;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
            if (req_fire) begin
                r_stamp <= r_stamp + 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.capacity_in_use;
            end
        end
    end

    // request word latch
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_action <= i_req.action;
            r_key    <= i_req.key;
            r_value  <= i_req.value;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (commit_go) begin
            r_out_hit     <= n_out_hit;
            r_out_rdata   <= n_out_rdata;
            r_out_evicted <= n_out_evicted;
            r_out_ekey    <= n_out_ekey;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_rdata;
    assign o_rsp.evicted     = r_out_evicted;
    assign o_rsp.evicted_key = r_out_ekey;

    // checks
    `LCT_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_W'(ENTRIES))
    `LCT_ASSERT_IMP(a_rsp_from_commit, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_COMMIT))
    `LCT_ASSERT_IMP(a_hit_no_evict, i_clk, i_rst_n, r_out_valid, !(r_out_hit && r_out_evicted))
    `LCT_ASSERT_NXT(a_walk_start, i_clk, i_rst_n, req_fire, (r_state == S_WALK) && (r_hop == '0))
    `LCT_ASSERT_NXT(a_stamp_step, i_clk, i_rst_n, req_fire, r_stamp == STAMP_W'($past(r_stamp) + 1'b1))

endmodule

@@ sim/lfu_cache_table_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for lfu_cache_table: directed and random get/put traffic
// checked against a local lfu predictor; depends on lct_pkg and the lct_*_if interfaces
module lfu_cache_table_test
    import lct_pkg::*;
;
    localparam int NUM_SLOTS  = ENTRIES_DEF;
    localparam int KEY_W      = KEY_BITS_DEF;
    localparam int RSP_LAT    = NUM_SLOTS + 2;
    localparam int TIMEOUT_NS = 2000000;

    // one response word as the block should return it
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
    } t_lookup_rsp;

    logic clk;
    logic rst_n;

    lct_req_if #(.KEY_W(KEY_W)) req_bus ();
    lct_rsp_if #(.KEY_W(KEY_W)) rsp_bus ();
    lct_cfg_if                  cfg_bus ();

    lfu_cache_table #(
        .ENTRIES  (NUM_SLOTS),
        .KEY_BITS (KEY_W)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    // predictor state: table contents, stamp counter, fill level, capacity register
    logic                slot_valid [NUM_SLOTS];
    logic [KEY_W-1:0]    slot_key   [NUM_SLOTS];
    logic [DATA_W-1:0]   slot_data  [NUM_SLOTS];
    logic [CNT_W-1:0]    slot_uses  [NUM_SLOTS];
    logic [STAMP_W-1:0]  slot_stamp [NUM_SLOTS];
    logic [STAMP_W-1:0]  stamp_now;
    int                  fill_count;
    logic [CFG_W-1:0]    cap_reg;

    t_lookup_rsp due_rsp_q[$];
    int          mismatches;
    bit          quiet;
    int          rx_hold;

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // lfu lookup with oldest-stamp tiebreak, one call per accepted request word
    function automatic t_lookup_rsp lfu_access(input logic act, input logic [KEY_W-1:0] key,
                                               input logic [DATA_W-1:0] value);
        t_lookup_rsp r;
        int          found;
        int          victim;
        int          slot;
        int          cap;
        r      = '0;
        found  = -1;
        victim = -1;
        slot   = -1;
        cap    = (cap_reg == 0) ? 1 : ((cap_reg > NUM_SLOTS) ? NUM_SLOTS : int'(cap_reg));
        stamp_now = stamp_now + 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
        end
        if (found >= 0) begin
            r.hit = 1'b1;
            if (slot_uses[found] != CNT_MAX) slot_uses[found] = slot_uses[found] + 1'b1;
            slot_stamp[found] = stamp_now;
            if (act == ACT_PUT) slot_data[found] = value;
            else r.read_value = slot_data[found];
        end else if (act == ACT_PUT) begin
            // full: pick lowest count, then oldest stamp, then lowest index
            if (fill_count >= cap) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                        (slot_uses[i] == slot_uses[victim] &&
                         slot_stamp[i] < slot_stamp[victim]))) victim = i;
                end
                if (victim >= 0) begin
                    r.evicted     = 1'b1;
                    r.evicted_key = slot_key[victim];
                    slot_valid[victim] = 1'b0;
                    fill_count--;
                    slot = victim;
                end
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot < 0 && !slot_valid[i]) slot = i;
            end
            if (slot >= 0) begin
                slot_valid[slot] = 1'b1;
                slot_key[slot]   = key;
                slot_data[slot]  = value;
                slot_uses[slot]  = CNT_W'(1);
                slot_stamp[slot] = stamp_now;
                fill_count++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got %0h want %0h at %0t ns", what, got, want, $time);
    endtask

    function automatic int sender_gap();
        if (quiet || $urandom_range(99) >= 15) return 0;
        return int'($urandom_range(1, 4));
    endfunction

    // send one request word, predict its response on acceptance
    task automatic send_op(input logic act, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] value);
        int gap;
        gap = sender_gap();
        repeat (gap) begin
            @(negedge clk);
            req_bus.valid = 1'b0;
        end
        @(negedge clk);
        req_bus.valid  = 1'b1;
        req_bus.action = act;
        req_bus.key    = key;
        req_bus.value  = value;
        do @(posedge clk); while (!req_bus.ready);
        due_rsp_q.push_back(lfu_access(act, key, value));
    endtask

    // random word drawn mostly from a small key pool so that hits and evictions are common
    task automatic send_random(input logic [KEY_W-1:0] base, input int pool);
        logic [KEY_W-1:0] key;
        logic             act;
        act = ($urandom_range(99) < 50) ? ACT_PUT : ACT_GET;
        if ($urandom_range(99) < 10) key = KEY_W'($urandom);
        else key = KEY_W'(base + $urandom_range(0, pool));
        send_op(act, key, $urandom);
    endtask

    // stop sending and wait for every outstanding response
    task automatic wait_drained();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (due_rsp_q.size() != 0) @(posedge clk);
    endtask

    // capacity write, only called once the table is idle
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        @(negedge clk);
        cfg_bus.valid           = 1'b1;
        cfg_bus.capacity_in_use = cap;
        do @(posedge clk); while (!cfg_bus.ready);
        cap_reg = cap;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // response receiver: random stalls plus a counted hold-off
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                rsp_bus.ready = 1'b0;
                rx_hold--;
            end else if (quiet) begin
                rsp_bus.ready = 1'b1;
            end else begin
                rsp_bus.ready = ($urandom_range(99) >= 15);
            end
        end
    end

    // response checker
    always @(posedge clk) begin : rsp_check
        t_lookup_rsp want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (due_rsp_q.size() == 0) begin
                report_mismatch("unexpected response word", 64'd0, 64'd0);
            end else begin
                want = due_rsp_q.pop_front();
                if (rsp_bus.hit !== want.hit)
                    report_mismatch("hit", 64'(rsp_bus.hit), 64'(want.hit));
                if (rsp_bus.read_value !== want.read_value)
                    report_mismatch("read_value", 64'(rsp_bus.read_value),
                                    64'(want.read_value));
                if (rsp_bus.evicted !== want.evicted)
                    report_mismatch("evicted", 64'(rsp_bus.evicted), 64'(want.evicted));
                if (rsp_bus.evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", 64'(rsp_bus.evicted_key),
                                    64'(want.evicted_key));
            end
        end
    end

    // empty table: misses, first inserts, update hit, extreme keys and values
    task automatic test_basic_access();
        send_op(ACT_GET, 16'h0000, 32'h1234_5678);
        send_op(ACT_PUT, 16'h0000, 32'h0000_0000);
        send_op(ACT_GET, 16'h0000, 32'hFFFF_FFFF);
        send_op(ACT_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(ACT_GET, 16'hFFFF, 32'h0000_0000);
        send_op(ACT_PUT, 16'h0000, 32'hA5A5_5A5A);
        send_op(ACT_GET, 16'h0000, 32'h0);
        send_op(ACT_GET, 16'h5555, 32'h0);
        wait_drained();
    endtask

    // capacity zero behaves as one: every new key pushes the previous one out
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_op(ACT_PUT, 16'hAAAA, 32'h0000_0001);
        send_op(ACT_PUT, 16'h5555, 32'h0000_0002);
        send_op(ACT_GET, 16'hAAAA, 32'h0);
        send_op(ACT_GET, 16'h5555, 32'h0);
        wait_drained();
    endtask

    // lowest count goes first, equal counts fall back to the oldest stamp
    task automatic test_frequency_order();
        write_capacity(5'd3);
        send_op(ACT_PUT, 16'h0101, 32'h0000_0101);
        send_op(ACT_PUT, 16'h0102, 32'h0000_0102);
        send_op(ACT_PUT, 16'h0103, 32'h0000_0103);
        send_op(ACT_GET, 16'h0101, 32'h0);
        send_op(ACT_GET, 16'h0101, 32'h0);
        send_op(ACT_PUT, 16'h0102, 32'h0000_0202);
        send_op(ACT_PUT, 16'h0104, 32'h0000_0104);
        send_op(ACT_PUT, 16'h0105, 32'h0000_0105);
        send_op(ACT_GET, 16'h0102, 32'h0);
        wait_drained();
    endtask

    // capacity dropped under the fill level: each put miss swaps one entry
    task automatic test_capacity_shrink();
        write_capacity(5'd1);
        send_op(ACT_PUT, 16'h0201, 32'hDEAD_BEEF);
        send_op(ACT_PUT, 16'h0202, 32'hCAFE_F00D);
        wait_drained();
        write_capacity(5'd31);
    endtask

    // random traffic over a range of capacities, one phase without any idling
    task automatic test_random_traffic();
        int               caps[9];
        logic [KEY_W-1:0] base;
        int               pool;
        int               eff;
        caps = '{16, 4, 1, 0, 31, 8, 2, 17, 5};
        foreach (caps[p]) begin
            wait_drained();
            write_capacity(CFG_W'(caps[p]));
            quiet = (p == 5);
            eff   = (caps[p] == 0) ? 1 : ((caps[p] > NUM_SLOTS) ? NUM_SLOTS : caps[p]);
            pool  = 2 * eff + 1;
            base  = KEY_W'($urandom_range(0, 16'hFFC0));
            repeat (80) send_random(base, pool);
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    // receiver holds off so the block fills and stalls its input, then a full drain
    task automatic test_output_stall();
        logic [KEY_W-1:0] base;
        base    = KEY_W'($urandom_range(0, 16'hFFC0));
        rx_hold = 150;
        repeat (12) send_random(base, 20);
        wait_drained();
    endtask

    initial begin
        rst_n                   = 1'b0;
        req_bus.valid           = 1'b0;
        req_bus.action          = ACT_GET;
        req_bus.key             = '0;
        req_bus.value           = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.capacity_in_use = '0;
        quiet                   = 1'b0;
        rx_hold                 = 0;
        mismatches              = 0;
        stamp_now               = '0;
        fill_count              = 0;
        cap_reg                 = CAP_RESET;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_data[i]  = '0;
            slot_uses[i]  = '0;
            slot_stamp[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_access();
        test_capacity_zero();
        test_frequency_order();
        test_capacity_shrink();
        test_random_traffic();
        test_output_stall();

        // let any stray response show up before the verdict
        wait_drained();
        repeat (RSP_LAT + 4) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
